[rtl/core/tlq_pkg.sv]
// Shared types, widths and corner codes for the thick line quad expander.
package tlq_pkg;

   // Field widths
   localparam int COORD_W = 16;
   localparam int HW_W    = 12;
   localparam int RGBA_W  = 32;

   // Derived datapath widths
   localparam int DIFF_W  = COORD_W + 1;            // endpoint difference
   localparam int MAG_W   = COORD_W;                // |difference|
   localparam int SQ_W    = 2 * MAG_W;              // one square
   localparam int SUM_W   = SQ_W + 1;               // dx*dx + dy*dy
   localparam int RAD_W   = ((SUM_W + 17) / 2) * 2; // (sum << 16), even width
   localparam int ROOT_W  = RAD_W / 2;              // length, 8 fraction bits
   localparam int REM_W   = ROOT_W + 3;
   localparam int PROD_W  = HW_W + MAG_W;           // half width * |d|
   localparam int NUM_W   = PROD_W + 10;            // 2*prod*256 + root
   localparam int DEN_W   = ROOT_W + 1;             // 2*root
   localparam int QUO_W   = HW_W;                   // offset never exceeds hw
   localparam int VTX_W   = COORD_W + 3;

   typedef enum logic [1:0] {
      CORNER_P1_PLUS  = 2'd0,
      CORNER_P1_MINUS = 2'd1,
      CORNER_P2_MINUS = 2'd2,
      CORNER_P2_PLUS  = 2'd3
   } tlq_corner_type;

   typedef struct packed {
      logic signed [COORD_W-1:0] start_x;
      logic signed [COORD_W-1:0] start_y;
      logic signed [COORD_W-1:0] end_x;
      logic signed [COORD_W-1:0] end_y;
      logic [HW_W-1:0]           half_width;
      logic [RGBA_W-1:0]         rgba;
   } tlq_req_type;

   typedef struct packed {
      logic signed [COORD_W-1:0] vert_x;
      logic signed [COORD_W-1:0] vert_y;
      logic [RGBA_W-1:0]         vert_rgba;
      tlq_corner_type            corner;
      logic                      degenerate;
      logic                      last;
   } tlq_rsp_type;

   // Item context carried down the pipeline next to the length/divide math
   typedef struct packed {
      logic signed [COORD_W-1:0] x1;
      logic signed [COORD_W-1:0] y1;
      logic signed [COORD_W-1:0] x2;
      logic signed [COORD_W-1:0] y2;
      logic [RGBA_W-1:0]         rgba;
      logic                      degen;
      logic                      neg_x;
      logic                      neg_y;
      logic [PROD_W-1:0]         prod_x;
      logic [PROD_W-1:0]         prod_y;
   } tlq_geom_type;

endpackage

[rtl/core/thick_line_quad_expand_core.sv]
// Throughput: four vertices per segment, one vertex a cycle while rsp_ready
//   is high; the single result channel limits how often a segment is taken.
// The 3 setup stages, 25 square root stages and 12 divide stages advance
//   together and take a new item in every cycle in which the output frees.
// Reset clears every valid bit; no item is lost or repeated across a stall.
module thick_line_quad_expand_core (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  tlq_pkg::tlq_req_type  req_data,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output tlq_pkg::tlq_rsp_type  rsp_data
);
   import tlq_pkg::*;

   localparam logic signed [VTX_W-1:0] VMAX = VTX_W'((1 << (COORD_W - 1)) - 1);
   localparam logic signed [VTX_W-1:0] VMIN = -VMAX - VTX_W'(1);

   function automatic logic signed [COORD_W-1:0] sat(input logic signed [VTX_W-1:0] v);
      logic signed [VTX_W-1:0] c;
      c = (v > VMAX) ? VMAX : ((v < VMIN) ? VMIN : v);
      return c[COORD_W-1:0];
   endfunction

   logic adv;

   // stage 1: register item, form normal
   logic                     s1_valid_ff;
   tlq_req_type              s1_req_ff;
   logic signed [DIFF_W-1:0] s1_dx_ff;
   logic signed [DIFF_W-1:0] s1_dy_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (adv) begin
         s1_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         s1_req_ff <= req_data;
         s1_dx_ff  <= DIFF_W'(req_data.end_y) - DIFF_W'(req_data.start_y);
         s1_dy_ff  <= DIFF_W'(req_data.start_x) - DIFF_W'(req_data.end_x);
      end
   end

   // stage 2: magnitudes, squares and half width products
   logic [MAG_W-1:0]  mag_x;
   logic [MAG_W-1:0]  mag_y;
   logic [DIFF_W-1:0] neg_dx;
   logic [DIFF_W-1:0] neg_dy;
   tlq_geom_type      s2_geom_in;
   logic              s2_valid_ff;
   tlq_geom_type      s2_geom_ff;
   logic [SQ_W-1:0]   s2_sqx_ff;
   logic [SQ_W-1:0]   s2_sqy_ff;

   always_comb begin
      neg_dx = -s1_dx_ff;
      neg_dy = -s1_dy_ff;
      mag_x  = s1_dx_ff[DIFF_W-1] ? neg_dx[MAG_W-1:0] : s1_dx_ff[MAG_W-1:0];
      mag_y  = s1_dy_ff[DIFF_W-1] ? neg_dy[MAG_W-1:0] : s1_dy_ff[MAG_W-1:0];
      s2_geom_in.x1     = s1_req_ff.start_x;
      s2_geom_in.y1     = s1_req_ff.start_y;
      s2_geom_in.x2     = s1_req_ff.end_x;
      s2_geom_in.y2     = s1_req_ff.end_y;
      s2_geom_in.rgba   = s1_req_ff.rgba;
      s2_geom_in.degen  = (s1_dx_ff == '0) && (s1_dy_ff == '0);
      s2_geom_in.neg_x  = s1_dx_ff[DIFF_W-1];
      s2_geom_in.neg_y  = s1_dy_ff[DIFF_W-1];
      s2_geom_in.prod_x = PROD_W'(s1_req_ff.half_width) * PROD_W'(mag_x);
      s2_geom_in.prod_y = PROD_W'(s1_req_ff.half_width) * PROD_W'(mag_y);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_valid_ff <= 1'b0;
      end else if (adv) begin
         s2_valid_ff <= s1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         s2_geom_ff <= s2_geom_in;
         s2_sqx_ff  <= SQ_W'(mag_x) * SQ_W'(mag_x);
         s2_sqy_ff  <= SQ_W'(mag_y) * SQ_W'(mag_y);
      end
   end

   // stage 3: squared length
   logic             s3_valid_ff;
   tlq_geom_type     s3_geom_ff;
   logic [SUM_W-1:0] s3_sum_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s3_valid_ff <= 1'b0;
      end else if (adv) begin
         s3_valid_ff <= s2_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         s3_geom_ff <= s2_geom_ff;
         s3_sum_ff  <= SUM_W'(s2_sqx_ff) + SUM_W'(s2_sqy_ff);
      end
   end

   // length with 8 fraction bits
   logic              sq_valid;
   logic [ROOT_W-1:0] sq_root;
   tlq_geom_type      sq_geom;

   tlq_sqrt u_sqrt (
      .clock     (clock),
      .reset     (reset),
      .en        (adv),
      .in_valid  (s3_valid_ff),
      .in_rad    (RAD_W'({s3_sum_ff, 16'b0})),
      .in_geom   (s3_geom_ff),
      .out_valid (sq_valid),
      .out_root  (sq_root),
      .out_geom  (sq_geom)
   );

   // offset magnitudes
   logic             dv_valid;
   logic [QUO_W-1:0] dv_qx;
   logic [QUO_W-1:0] dv_qy;
   tlq_geom_type     dv_geom;

   tlq_div u_div (
      .clock     (clock),
      .reset     (reset),
      .en        (adv),
      .in_valid  (sq_valid),
      .in_root   (sq_root),
      .in_geom   (sq_geom),
      .out_valid (dv_valid),
      .out_qx    (dv_qx),
      .out_qy    (dv_qy),
      .out_geom  (dv_geom)
   );

   // output stage: holds one quad and walks its four corners
   logic             hold_valid_ff;
   tlq_geom_type     hold_geom_ff;
   logic [QUO_W-1:0] hold_qx_ff;
   logic [QUO_W-1:0] hold_qy_ff;
   tlq_corner_type   corner_ff;
   logic             rsp_take;

   assign rsp_take  = rsp_valid && rsp_ready;
   assign adv       = !hold_valid_ff || (rsp_ready && corner_ff == CORNER_P2_PLUS);
   assign req_ready = adv;

   always_ff @(posedge clock) begin
      if (reset) begin
         hold_valid_ff <= 1'b0;
         corner_ff     <= CORNER_P1_PLUS;
      end else if (adv) begin
         hold_valid_ff <= dv_valid;
         corner_ff     <= CORNER_P1_PLUS;
      end else if (rsp_take) begin
         corner_ff     <= tlq_corner_type'(corner_ff + 2'd1);
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         hold_geom_ff <= dv_geom;
         hold_qx_ff   <= dv_qx;
         hold_qy_ff   <= dv_qy;
      end
   end

   // vertex = endpoint +/- signed offset, then saturate
   logic                     first_pt;
   logic                     plus;
   logic signed [VTX_W-1:0]  ox;
   logic signed [VTX_W-1:0]  oy;
   logic signed [VTX_W-1:0]  px;
   logic signed [VTX_W-1:0]  py;
   logic signed [VTX_W-1:0]  vx;
   logic signed [VTX_W-1:0]  vy;

   always_comb begin
      first_pt = (corner_ff == CORNER_P1_PLUS) || (corner_ff == CORNER_P1_MINUS);
      plus     = (corner_ff == CORNER_P1_PLUS) || (corner_ff == CORNER_P2_PLUS);
      ox = VTX_W'(hold_qx_ff);
      oy = VTX_W'(hold_qy_ff);
      if (hold_geom_ff.neg_x) begin
         ox = -ox;
      end
      if (hold_geom_ff.neg_y) begin
         oy = -oy;
      end
      if (hold_geom_ff.degen) begin
         ox = '0;
         oy = '0;
      end
      px = first_pt ? VTX_W'(hold_geom_ff.x1) : VTX_W'(hold_geom_ff.x2);
      py = first_pt ? VTX_W'(hold_geom_ff.y1) : VTX_W'(hold_geom_ff.y2);
      vx = plus ? (px + ox) : (px - ox);
      vy = plus ? (py + oy) : (py - oy);
   end

   always_comb begin
      rsp_valid            = hold_valid_ff;
      rsp_data.vert_x      = sat(vx);
      rsp_data.vert_y      = sat(vy);
      rsp_data.vert_rgba   = hold_geom_ff.rgba;
      rsp_data.corner      = corner_ff;
      rsp_data.degenerate  = hold_geom_ff.degen;
      rsp_data.last        = (corner_ff == CORNER_P2_PLUS);
   end

endmodule

[rtl/core/tlq_sqrt.sv]
// Pipelined integer square root, one result bit per stage, with item context.
module tlq_sqrt (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      en,
   input  logic                      in_valid,
   input  logic [tlq_pkg::RAD_W-1:0] in_rad,
   input  tlq_pkg::tlq_geom_type     in_geom,
   output logic                      out_valid,
   output logic [tlq_pkg::ROOT_W-1:0] out_root,
   output tlq_pkg::tlq_geom_type     out_geom
);
   import tlq_pkg::*;

   logic [ROOT_W-1:0] vld_ff;
   logic [REM_W-1:0]  rem_ff  [ROOT_W];
   logic [ROOT_W-1:0] root_ff [ROOT_W];
   logic [RAD_W-1:0]  rad_ff  [ROOT_W];
   tlq_geom_type      geom_ff [ROOT_W];

   for (genvar k = 0; k < ROOT_W; k++) begin : g_stage
      logic              vld_prev;
      logic [REM_W-1:0]  rem_prev;
      logic [ROOT_W-1:0] root_prev;
      logic [RAD_W-1:0]  rad_prev;
      tlq_geom_type      geom_prev;
      logic [REM_W-1:0]  rem_cat;
      logic [REM_W-1:0]  trial;
      logic              ge;
      logic [REM_W-1:0]  rem_in;
      logic [ROOT_W-1:0] root_in;

      if (k == 0) begin : g_first
         assign vld_prev  = in_valid;
         assign rem_prev  = '0;
         assign root_prev = '0;
         assign rad_prev  = in_rad;
         assign geom_prev = in_geom;
      end else begin : g_next
         assign vld_prev  = vld_ff[k-1];
         assign rem_prev  = rem_ff[k-1];
         assign root_prev = root_ff[k-1];
         assign rad_prev  = rad_ff[k-1];
         assign geom_prev = geom_ff[k-1];
      end

      // bring down two radicand bits, try root*4+1
      always_comb begin
         rem_cat = {rem_prev[REM_W-3:0], rad_prev[RAD_W-1 -: 2]};
         trial   = REM_W'({root_prev, 2'b01});
         ge      = (rem_cat >= trial);
         rem_in  = ge ? (rem_cat - trial) : rem_cat;
         root_in = {root_prev[ROOT_W-2:0], ge};
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            vld_ff[k] <= 1'b0;
         end else if (en) begin
            vld_ff[k] <= vld_prev;
         end
      end

      always_ff @(posedge clock) begin
         if (en) begin
            rem_ff[k]  <= rem_in;
            root_ff[k] <= root_in;
            rad_ff[k]  <= rad_prev << 2;
            geom_ff[k] <= geom_prev;
         end
      end
   end

   assign out_valid = vld_ff[ROOT_W-1];
   assign out_root  = root_ff[ROOT_W-1];
   assign out_geom  = geom_ff[ROOT_W-1];

endmodule

[rtl/core/tlq_div.sv]
// Pipelined restoring divider, two lanes sharing one divisor, rounds to nearest.
module tlq_div (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       en,
   input  logic                       in_valid,
   input  logic [tlq_pkg::ROOT_W-1:0] in_root,
   input  tlq_pkg::tlq_geom_type      in_geom,
   output logic                       out_valid,
   output logic [tlq_pkg::QUO_W-1:0]  out_qx,
   output logic [tlq_pkg::QUO_W-1:0]  out_qy,
   output tlq_pkg::tlq_geom_type      out_geom
);
   import tlq_pkg::*;

   logic [QUO_W-1:0] vld_ff;
   logic [NUM_W-1:0] nx_ff   [QUO_W];
   logic [NUM_W-1:0] ny_ff   [QUO_W];
   logic [QUO_W-1:0] qx_ff   [QUO_W];
   logic [QUO_W-1:0] qy_ff   [QUO_W];
   logic [DEN_W-1:0] den_ff  [QUO_W];
   tlq_geom_type     geom_ff [QUO_W];

   for (genvar k = 0; k < QUO_W; k++) begin : g_stage
      logic             vld_prev;
      logic [NUM_W-1:0] nx_prev;
      logic [NUM_W-1:0] ny_prev;
      logic [QUO_W-1:0] qx_prev;
      logic [QUO_W-1:0] qy_prev;
      logic [DEN_W-1:0] den_prev;
      tlq_geom_type     geom_prev;
      logic [NUM_W-1:0] den_sh;
      logic             ge_x;
      logic             ge_y;

      if (k == 0) begin : g_first
         // numerator 2*hw*|d|*256 + root, divisor 2*root
         assign vld_prev  = in_valid;
         assign nx_prev   = NUM_W'({in_geom.prod_x, 9'b0}) + NUM_W'(in_root);
         assign ny_prev   = NUM_W'({in_geom.prod_y, 9'b0}) + NUM_W'(in_root);
         assign qx_prev   = '0;
         assign qy_prev   = '0;
         assign den_prev  = {in_root, 1'b0};
         assign geom_prev = in_geom;
      end else begin : g_next
         assign vld_prev  = vld_ff[k-1];
         assign nx_prev   = nx_ff[k-1];
         assign ny_prev   = ny_ff[k-1];
         assign qx_prev   = qx_ff[k-1];
         assign qy_prev   = qy_ff[k-1];
         assign den_prev  = den_ff[k-1];
         assign geom_prev = geom_ff[k-1];
      end

      // trial subtract of the divisor at this quotient bit
      always_comb begin
         den_sh = NUM_W'(den_prev) << (QUO_W - 1 - k);
         ge_x   = (nx_prev >= den_sh);
         ge_y   = (ny_prev >= den_sh);
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            vld_ff[k] <= 1'b0;
         end else if (en) begin
            vld_ff[k] <= vld_prev;
         end
      end

      always_ff @(posedge clock) begin
         if (en) begin
            nx_ff[k]   <= ge_x ? (nx_prev - den_sh) : nx_prev;
            ny_ff[k]   <= ge_y ? (ny_prev - den_sh) : ny_prev;
            qx_ff[k]   <= {qx_prev[QUO_W-2:0], ge_x};
            qy_ff[k]   <= {qy_prev[QUO_W-2:0], ge_y};
            den_ff[k]  <= den_prev;
            geom_ff[k] <= geom_prev;
         end
      end
   end

   assign out_valid = vld_ff[QUO_W-1];
   assign out_qx    = qx_ff[QUO_W-1];
   assign out_qy    = qy_ff[QUO_W-1];
   assign out_geom  = geom_ff[QUO_W-1];

endmodule

[rtl/core/tlq_checker.sv]
// Port level checks for the thick line quad expander, bound to the top level.
module tlq_checker (
   input logic                 clock,
   input logic                 reset,
   input logic                 req_ready,
   input logic                 rsp_valid,
   input logic                 rsp_ready,
   input tlq_pkg::tlq_rsp_type rsp_data
);
   import tlq_pkg::*;

   // a stalled vertex holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
      else $error("stalled vertex changed");

   // the four corners of a quad come without a gap
   a_quad_run: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_ready && !rsp_data.last |=> rsp_valid)
      else $error("quad broken off");

   // corners step by one within a quad
   a_corner_step: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_ready && !rsp_data.last |=>
         rsp_data.corner == tlq_corner_type'($past(rsp_data.corner) + 2'd1))
      else $error("corner out of order");

   // last marks the fourth corner only
   a_last_corner: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_data.last == (rsp_data.corner == CORNER_P2_PLUS)))
      else $error("last on wrong corner");

   // no new segment taken while a quad is mid-way
   a_no_take_mid: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !(rsp_ready && rsp_data.last) |-> !req_ready)
      else $error("input taken mid quad");

endmodule

bind thick_line_quad_expand_core tlq_checker u_tlq_checker (
   .clock     (clock),
   .reset     (reset),
   .req_ready (req_ready),
   .rsp_valid (rsp_valid),
   .rsp_ready (rsp_ready),
   .rsp_data  (rsp_data)
);

[tb/tb_thick_line_quad_expand_core.sv]
// Self-checking testbench for the thick line quad expander core.
module tb_thick_line_quad_expand_core;
   import tlq_pkg::*;

   localparam int RANDOM_SEGS = 320;
   localparam int IDLE_LIMIT  = 20000;
   localparam int DRAIN_WAIT  = 100;

   logic        clock;
   logic        reset;
   logic        req_valid;
   logic        req_ready;
   tlq_req_type req_data;
   logic        rsp_valid;
   logic        rsp_ready;
   tlq_rsp_type rsp_data;

   thick_line_quad_expand_core i_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   // Directed row: segment plus optional typed-in vertices
   typedef struct {
      tlq_req_type seg;
      bit          has_verts;
      tlq_rsp_type verts [4];
   } seg_row_type;

   tlq_rsp_type vertex_queue[$];
   seg_row_type seg_rows[$];
   int          mismatch_count;
   int          vertex_count;
   int          degen_count;
   int          sat_count;
   int          idle_cycles;
   bit          hold_off;

   always begin
      clock = 1'b1; #1;
      clock = 1'b0; #1;
   end

   // Integer square root, bit by bit
   function automatic longint unsigned root_of(input longint unsigned v);
      longint unsigned res;
      longint unsigned b;
      res = 0;
      b = 64'd1 << 62;
      while (b > v) b = b >> 2;
      while (b != 0) begin
         if (v >= res + b) begin
            v = v - (res + b);
            res = (res >> 1) + b;
         end else begin
            res = res >> 1;
         end
         b = b >> 2;
      end
      return res;
   endfunction

   function automatic longint offset_comp(input longint d, input longint unsigned hw,
                                          input longint unsigned len);
      longint unsigned num;
      longint unsigned q;
      num = hw * longint'(d < 0 ? -d : d) * 256;
      q = (2 * num + len) / (2 * len);
      return d < 0 ? -longint'(q) : longint'(q);
   endfunction

   function automatic logic signed [COORD_W-1:0] clamp_coord(input longint v);
      longint hi;
      longint lo;
      hi = (longint'(1) << (COORD_W - 1)) - 1;
      lo = -hi - 1;
      if (v > hi) return hi[COORD_W-1:0];
      if (v < lo) return lo[COORD_W-1:0];
      return v[COORD_W-1:0];
   endfunction

   // Expand one segment into its four quad vertices
   task automatic expand_quad(input tlq_req_type s, output tlq_rsp_type q [4]);
      longint          x1, y1, x2, y2, nx, ny, ox, oy, px, py, vx, vy;
      longint unsigned len;
      bit              degen;
      x1 = s.start_x; y1 = s.start_y; x2 = s.end_x; y2 = s.end_y;
      nx = y2 - y1;
      ny = x1 - x2;
      ox = 0; oy = 0;
      // halve very long normals (only reachable for wide coordinates)
      while ((nx >= (64'sd1 << 20)) || (-nx >= (64'sd1 << 20)) ||
             (ny >= (64'sd1 << 20)) || (-ny >= (64'sd1 << 20))) begin
         nx = nx >>> 1;
         ny = ny >>> 1;
      end
      degen = (nx == 0) && (ny == 0);
      if (!degen) begin
         len = root_of(longint'(nx * nx + ny * ny) << 16);
         ox = offset_comp(nx, longint'(s.half_width), len);
         oy = offset_comp(ny, longint'(s.half_width), len);
      end
      for (int k = 0; k < 4; k++) begin
         px = (k < 2) ? x1 : x2;
         py = (k < 2) ? y1 : y2;
         vx = (k == 0 || k == 3) ? px + ox : px - ox;
         vy = (k == 0 || k == 3) ? py + oy : py - oy;
         q[k].vert_x     = clamp_coord(vx);
         q[k].vert_y     = clamp_coord(vy);
         q[k].vert_rgba  = s.rgba;
         q[k].corner     = tlq_corner_type'(k);
         q[k].degenerate = degen;
         q[k].last       = (k == 3);
         if (clamp_coord(vx) != vx || clamp_coord(vy) != vy) sat_count++;
      end
   endtask

   task automatic report_mismatch(input string what, input tlq_rsp_type got,
                                  input tlq_rsp_type want);
      mismatch_count++;
      $display("MISMATCH %s: got %h, want %h", what, got, want);
   endtask

   function automatic tlq_req_type make_seg(input int x1, input int y1, input int x2,
                                            input int y2, input int hw,
                                            input logic [31:0] c);
      tlq_req_type s;
      s.start_x = COORD_W'(x1); s.start_y = COORD_W'(y1);
      s.end_x = COORD_W'(x2); s.end_y = COORD_W'(y2);
      s.half_width = HW_W'(hw); s.rgba = c;
      return s;
   endfunction

   function automatic tlq_req_type rand_seg();
      tlq_req_type s;
      int          mode;
      mode = $urandom_range(9);
      s.start_x = COORD_W'($urandom); s.start_y = COORD_W'($urandom);
      s.half_width = HW_W'($urandom); s.rgba = $urandom;
      if (mode < 5) begin
         // short segments, moderate offsets
         s.end_x = COORD_W'(int'(s.start_x) + int'($urandom_range(0, 4000)) - 2000);
         s.end_y = COORD_W'(int'(s.start_y) + int'($urandom_range(0, 4000)) - 2000);
      end else if (mode < 6) begin
         s.end_x = s.start_x; s.end_y = s.start_y;
      end else if (mode < 7) begin
         // axis-aligned
         s.end_x = s.start_x;
         s.end_y = COORD_W'($urandom);
      end else begin
         s.end_x = COORD_W'($urandom); s.end_y = COORD_W'($urandom);
      end
      return s;
   endfunction

   // Queue expected vertices for an accepted segment
   task automatic note_accepted(input seg_row_type row);
      tlq_rsp_type q [4];
      expand_quad(row.seg, q);
      for (int k = 0; k < 4; k++) begin
         if (row.has_verts && row.verts[k] != q[k])
            report_mismatch("typed row vs predictor", q[k], row.verts[k]);
         vertex_queue.push_back(row.has_verts ? row.verts[k] : q[k]);
      end
   endtask

   task automatic offer_seg(input seg_row_type row);
      req_data  <= row.seg;
      req_valid <= 1'b1;
      do @(posedge clock); while (!req_ready);
      note_accepted(row);
      @(negedge clock);
   endtask

   function automatic seg_row_type plain_row(input tlq_req_type s);
      seg_row_type r;
      r.seg = s;
      r.has_verts = 1'b0;
      return r;
   endfunction

   function automatic seg_row_type typed_row(input tlq_req_type s, input int ox,
                                             input int oy, input bit degen);
      seg_row_type r;
      r.seg = s;
      r.has_verts = 1'b1;
      for (int k = 0; k < 4; k++) begin
         longint px, py, vx, vy;
         px = (k < 2) ? s.start_x : s.end_x;
         py = (k < 2) ? s.start_y : s.end_y;
         vx = (k == 0 || k == 3) ? px + ox : px - ox;
         vy = (k == 0 || k == 3) ? py + oy : py - oy;
         r.verts[k].vert_x = clamp_coord(vx);
         r.verts[k].vert_y = clamp_coord(vy);
         r.verts[k].vert_rgba = s.rgba;
         r.verts[k].corner = tlq_corner_type'(k);
         r.verts[k].degenerate = degen;
         r.verts[k].last = (k == 3);
      end
      return r;
   endfunction

   // Directed table
   initial begin
      // coincident endpoints: zero offset, degenerate
      seg_rows.push_back(typed_row(make_seg(0, 0, 0, 0, 4095, 32'h0), 0, 0, 1));
      seg_rows.push_back(typed_row(make_seg(-32768, 32767, -32768, 32767, 4095,
                                            32'hFFFF_FFFF), 0, 0, 1));
      // horizontal line: normal is (0, -dx) scaled to hw
      seg_rows.push_back(typed_row(make_seg(0, 0, 160, 0, 16, 32'h1234_5678), 0, -16, 0));
      // vertical line: normal along +x
      seg_rows.push_back(typed_row(make_seg(0, 0, 0, 160, 4095, 32'hA5A5_A5A5), 4095, 0, 0));
      // zero half width
      seg_rows.push_back(typed_row(make_seg(100, -100, 900, 700, 0, 32'h5A5A_5A5A), 0, 0, 0));
      // saturation at both extremes
      seg_rows.push_back(typed_row(make_seg(32767, 32767, 32767, -32768, 4095,
                                            32'h8000_0001), -4095, 0, 0));
      seg_rows.push_back(typed_row(make_seg(-32768, -32768, 32767, -32768, 4095,
                                            32'h7FFF_FFFE), 0, -4095, 0));
      // full-length diagonals and small slopes, predictor-checked
      seg_rows.push_back(plain_row(make_seg(-32768, -32768, 32767, 32767, 4095, 32'h1)));
      seg_rows.push_back(plain_row(make_seg(32767, -32768, -32768, 32767, 2048, 32'h2)));
      seg_rows.push_back(plain_row(make_seg(0, 0, 1, 1, 1, 32'h3)));
      seg_rows.push_back(plain_row(make_seg(0, 0, 1, 2, 3, 32'h4)));
      seg_rows.push_back(plain_row(make_seg(5, 5, 4, 7, 4095, 32'h5)));
      seg_rows.push_back(plain_row(make_seg(-1, -1, 0, 0, 2047, 32'h6)));
      seg_rows.push_back(plain_row(make_seg(1000, 2000, -3000, 1500, 777, 32'h7)));
   end

   // Receiver: random stalls plus one long hold-off
   initial begin
      rsp_ready = 1'b0;
      @(negedge clock);
      while (1) begin
         if (hold_off) begin
            rsp_ready <= 1'b0;
            repeat (300) @(negedge clock);
            hold_off = 1'b0;
         end else begin
            case ($urandom_range(3))
               0: rsp_ready <= ($urandom_range(3) == 0);
               1: rsp_ready <= 1'b1;
               default: rsp_ready <= ($urandom_range(1) == 0);
            endcase
            @(negedge clock);
         end
      end
   end

   // Check vertices at the rising edge
   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         vertex_count++;
         if (rsp_data.degenerate) degen_count++;
         if (vertex_queue.size() == 0) begin
            mismatch_count++;
            $display("MISMATCH unexpected vertex x=%0d y=%0d", rsp_data.vert_x,
                     rsp_data.vert_y);
         end else begin
            tlq_rsp_type want;
            want = vertex_queue.pop_front();
            if (rsp_data != want) report_mismatch("vertex", rsp_data, want);
         end
      end
   end

   // Watchdog on cycles without any handshake
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready))
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
         $display("watchdog: no progress for %0d cycles", IDLE_LIMIT);
         $display("tb_thick_line_quad_expand_core failed");
         $finish;
      end
   end

   // Sender and end of run
   initial begin
      int burst;
      int gap;
      mismatch_count = 0;
      vertex_count = 0;
      degen_count = 0;
      sat_count = 0;
      reset = 1'b1;
      req_valid = 1'b0;
      req_data = '0;
      repeat (10) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      foreach (seg_rows[i]) offer_seg(seg_rows[i]);

      for (int n = 0; n < RANDOM_SEGS; ) begin
         burst = (n > 100 && n < 160) ? 60 : $urandom_range(1, 12);
         for (int b = 0; b < burst && n < RANDOM_SEGS; b++, n++) begin
            if (n == 100) hold_off = 1'b1;
            offer_seg(plain_row(rand_seg()));
         end
         gap = (n > 100 && n < 160) ? 0 : $urandom_range(0, 8);
         if (gap > 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(negedge clock);
         end
      end
      req_valid <= 1'b0;

      while (vertex_queue.size() != 0) @(negedge clock);
      repeat (DRAIN_WAIT) @(negedge clock);

      $display("ran %0d segments, checked %0d vertices (%0d degenerate, %0d clamped)",
               seg_rows.size() + RANDOM_SEGS, vertex_count, degen_count, sat_count);
      if (mismatch_count == 0 && vertex_queue.size() == 0) begin
         $display("tb_thick_line_quad_expand_core passed");
      end else begin
         $display("%0d mismatches, %0d vertices outstanding", mismatch_count,
                  vertex_queue.size());
         $display("tb_thick_line_quad_expand_core failed");
      end
      $finish;
   end

endmodule
